@@ sv/sha1mh_pkg.sv @@
// Shared types and constants of the SHA-1 message hasher.
// No dependencies; imported by sha1mh_round and sha1_message_hasher.
package sha1mh_pkg;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } sha1mh_words_t;

  localparam sha1mh_words_t IV = '{
    a: 32'h67452301,
    b: 32'hEFCDAB89,
    c: 32'h98BADCFE,
    d: 32'h10325476,
    e: 32'hC3D2E1F0
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam int unsigned NUM_ROUNDS = 80;
  localparam int unsigned ROUND_W    = 7;
  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(NUM_ROUNDS - 1);

endpackage

@@ sv/sha1_message_hasher.sv @@
// SHA-1 message hasher top level: byte intake, padding, round sequencer, digest output.
// Depends on sha1mh_pkg and sha1mh_round.
//
// Takes a message one byte per beat (tuser = byte valid, tlast = end of message) and
// returns the 160-bit digest as five 32-bit beats, h0 first, tlast on h4. The 64th byte
// of a block starts a compression on the single round unit, one round per cycle: the
// input is not ready during the 80 rounds and the chaining add. At end of message
// padding goes in one byte per cycle, then the two length words, then one or two
// compressions; the first digest beat also waits for the previous digest to drain.
// The digest sits in its own output buffer, so the next message can be taken while it
// drains; a second digest waits for the buffer.
module sha1_message_hasher import sha1mh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tuser_i,   // [0] has_byte
  input  logic        s_axis_tlast_i,   // last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] digest_word
  output logic        m_axis_tlast_o    // digest_last
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_LEN  = 3'd2;
  localparam logic [2:0] ST_COMP = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [60:0]         count_q, count_d;
  logic [5:0]          pos_q, pos_d;
  logic                fin_q, fin_d;
  logic                pad_first_q, pad_first_d;
  logic                len_sel_q, len_sel_d;
  logic                len_done_q, len_done_d;
  logic [ROUND_W-1:0]  round_q, round_d;
  sha1mh_words_t       chain_q, chain_d;
  sha1mh_words_t       work_q, work_d;
  logic [2:0]          out_left_q, out_left_d;

  logic [23:0]         acc_q, acc_d;
  logic [31:0]         win_q [16];
  logic [31:0]         win_d [16];
  logic [31:0]         dig_q [5];
  logic [31:0]         dig_d [5];

  logic                s_fire, m_fire;
  logic                ins_en;
  logic [7:0]          ins_byte;
  logic                push;
  logic [31:0]         push_word;
  logic [63:0]         bit_len;
  sha1mh_words_t       round_out;
  sha1mh_words_t       sum;
  logic [31:0]         w_next;

  sha1mh_round u_round (
    .words_i  (work_q),
    .round_i  (round_q),
    .w_i      (win_q[0]),
    .tap2_i   (win_q[2]),
    .tap8_i   (win_q[8]),
    .tap13_i  (win_q[13]),
    .words_o  (round_out),
    .w_next_o (w_next)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i & s_axis_tready_o;
  assign m_axis_tvalid_o = (out_left_q != 3'd0);
  assign m_axis_tdata_o  = dig_q[0];
  assign m_axis_tlast_o  = (out_left_q == 3'd1);
  assign m_fire          = m_axis_tvalid_o & m_axis_tready_i;

  assign bit_len = {count_q, 3'b000};

  assign sum.a = chain_q.a + work_q.a;
  assign sum.b = chain_q.b + work_q.b;
  assign sum.c = chain_q.c + work_q.c;
  assign sum.d = chain_q.d + work_q.d;
  assign sum.e = chain_q.e + work_q.e;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    fin_d       = fin_q;
    pad_first_d = pad_first_q;
    len_sel_d   = len_sel_q;
    len_done_d  = len_done_q;
    round_d     = round_q;
    chain_d     = chain_q;
    work_d      = work_q;
    out_left_d  = out_left_q;
    acc_d       = acc_q;
    win_d       = win_q;
    dig_d       = dig_q;
    ins_en      = 1'b0;
    ins_byte    = s_axis_tdata_i;
    push        = 1'b0;
    push_word   = '0;

    // digest buffer drains one word per beat
    if (m_fire) begin
      for (int i = 0; i < 4; i++) begin
        dig_d[i] = dig_q[i+1];
      end
      out_left_d = out_left_q - 3'd1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser_i) begin
            ins_en  = 1'b1;
            count_d = count_q + 61'd1;
          end
          if (s_axis_tuser_i && pos_q == 6'd63) begin
            state_d = ST_COMP;
            fin_d   = s_axis_tlast_i;
            pad_first_d = 1'b1;
            work_d  = chain_q;
            round_d = '0;
          end else if (s_axis_tlast_i) begin
            state_d     = ST_PAD;
            fin_d       = 1'b1;
            pad_first_d = 1'b1;
          end
        end
      end
      ST_PAD: begin
        ins_en      = 1'b1;
        ins_byte    = pad_first_q ? PAD_BYTE : 8'h00;
        pad_first_d = 1'b0;
        if (pos_q == 6'd63) begin
          state_d = ST_COMP;
          work_d  = chain_q;
          round_d = '0;
        end else if (pos_q == 6'd55) begin
          state_d   = ST_LEN;
          len_sel_d = 1'b0;
        end
      end
      ST_LEN: begin
        push      = 1'b1;
        push_word = len_sel_q ? bit_len[31:0] : bit_len[63:32];
        len_sel_d = 1'b1;
        if (len_sel_q) begin
          len_done_d = 1'b1;
          state_d    = ST_COMP;
          work_d     = chain_q;
          round_d    = '0;
        end
      end
      ST_COMP: begin
        work_d    = round_out;
        push      = 1'b1;
        push_word = w_next;
        round_d   = round_q + ROUND_W'(1);
        if (round_q == LAST_ROUND) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        priority if (!fin_q) begin
          chain_d = sum;
          state_d = ST_IDLE;
        end else if (!len_done_q) begin
          chain_d = sum;
          state_d = ST_PAD;
        end else if (out_left_q == 3'd0) begin
          dig_d[0]   = sum.a;
          dig_d[1]   = sum.b;
          dig_d[2]   = sum.c;
          dig_d[3]   = sum.d;
          dig_d[4]   = sum.e;
          out_left_d = 3'd5;
          chain_d    = IV;
          count_d    = '0;
          pos_d      = '0;
          fin_d      = 1'b0;
          len_done_d = 1'b0;
          state_d    = ST_IDLE;
        end else begin
          // hold until the previous digest has drained
          state_d = ST_FIN;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // byte intake: three bytes gather in acc, the fourth completes a word
    if (ins_en) begin
      pos_d = pos_q + 6'd1;
      acc_d = {acc_q[15:0], ins_byte};
      if (pos_q[1:0] == 2'd3) begin
        push      = 1'b1;
        push_word = {acc_q, ins_byte};
      end
    end

    // window shifts toward index 0; win[0] is the word of the current round
    if (push) begin
      for (int i = 0; i < 15; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[15] = push_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      fin_q       <= 1'b0;
      pad_first_q <= 1'b0;
      len_sel_q   <= 1'b0;
      len_done_q  <= 1'b0;
      round_q     <= '0;
      chain_q     <= IV;
      work_q      <= '0;
      out_left_q  <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      fin_q       <= fin_d;
      pad_first_q <= pad_first_d;
      len_sel_q   <= len_sel_d;
      len_done_q  <= len_done_d;
      round_q     <= round_d;
      chain_q     <= chain_d;
      work_q      <= work_d;
      out_left_q  <= out_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    win_q <= win_d;
    dig_q <= dig_d;
  end

endmodule

@@ sv/sha1mh_round.sv @@
// One SHA-1 round plus the next message schedule word.
// Depends on sha1mh_pkg.
module sha1mh_round import sha1mh_pkg::*; (
  input  sha1mh_words_t        words_i,
  input  logic [ROUND_W-1:0]   round_i,
  input  logic [31:0]          w_i,      // W[t]
  input  logic [31:0]          tap2_i,   // W[t+2]
  input  logic [31:0]          tap8_i,   // W[t+8]
  input  logic [31:0]          tap13_i,  // W[t+13]
  output sha1mh_words_t        words_o,
  output logic [31:0]          w_next_o  // W[t+16]
);

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;
  logic [31:0] x;

  always_comb begin
    priority if (round_i < ROUND_W'(20)) begin
      f = (words_i.b & words_i.c) | (~words_i.b & words_i.d);
      k = K0;
    end else if (round_i < ROUND_W'(40)) begin
      f = words_i.b ^ words_i.c ^ words_i.d;
      k = K1;
    end else if (round_i < ROUND_W'(60)) begin
      f = (words_i.b & words_i.c) | (words_i.b & words_i.d) | (words_i.c & words_i.d);
      k = K2;
    end else begin
      f = words_i.b ^ words_i.c ^ words_i.d;
      k = K3;
    end
  end

  assign t = {words_i.a[26:0], words_i.a[31:27]} + f + words_i.e + k + w_i;

  assign words_o.a = t;
  assign words_o.b = words_i.a;
  assign words_o.c = {words_i.b[1:0], words_i.b[31:2]};
  assign words_o.d = words_i.c;
  assign words_o.e = words_i.d;

  assign x        = w_i ^ tap2_i ^ tap8_i ^ tap13_i;
  assign w_next_o = {x[30:0], x[31]};

endmodule
